[hw/rtl/tlb_translate_fifo_lru_assert.svh]
// Assertion macros for the TLB block.
`ifndef TLB_TRANSLATE_FIFO_LRU_ASSERT_SVH
`define TLB_TRANSLATE_FIFO_LRU_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define TLB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define TLB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[hw/rtl/tlbt_pkg.sv]
// ----------------------------------------------------------------------------
// tlbt_pkg
// Types and constants shared by the TLB block.
// ----------------------------------------------------------------------------
package tlbt_pkg;
    localparam logic [1:0] ST_HIT   = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_FILL  = 2'd2;
    localparam logic [1:0] ST_ERROR = 2'd3;

    localparam logic [1:0] REG_PAGE_SIZE = 2'd0;
    localparam logic [1:0] REG_ENTRIES   = 2'd1;
    localparam logic [1:0] REG_MODE      = 2'd2;

    localparam logic [1:0] MODE_FIFO = 2'd0;
    localparam logic [1:0] MODE_LRU  = 2'd1;

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_FILL   = 1'b1;

    typedef struct packed {
        logic        func;
        logic [15:0] pid;
        logic [31:0] logical_address;
        logic [15:0] frame_from_table;
        logic        table_error;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] vpn;
        logic [31:0] physical_address;
    } t_out_item;

    // divider handshake
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [16:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
        logic [16:0] remainder;
    } t_div_rsp;
endpackage

[hw/rtl/tlbt_ram.sv]
// ----------------------------------------------------------------------------
// tlbt_ram
// Generic single-port write, single-port read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hw/rtl/tlbt_div.sv]
// ----------------------------------------------------------------------------
// tlbt_div
// Restoring divider, 32-bit dividend by 17-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module tlbt_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tlbt_pkg::t_div_req i_req,
    output tlbt_pkg::t_div_rsp o_rsp
);
    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [31:0] r_quo;
    logic [17:0] r_rem;
    logic [16:0] r_dvs;
    logic        r_done;
    logic [17:0] w_shift;
    logic [18:0] w_diff;

    assign w_shift = {r_rem[16:0], r_quo[31]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                if (!w_diff[18]) begin
                    r_rem <= w_diff[17:0];
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= w_shift;
                    r_quo <= {r_quo[30:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem[16:0];
endmodule

[hw/rtl/tlb_translate_fifo_lru.sv]
// Fully associative TLB tagged by process id and page number. One item is
// handled at a time: the bit-serial divider splits the address by the page
// size, a scan reads the N entries in use through the single read port of the
// entry memory (tag match, victim search), then the S_MUL state forms the
// product and the S_OUT state loads the result. A result waits in an output
// register; the next item is taken once that register is free. Entry valid
// bits are flip-flops cleared at reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
// tlb_translate_fifo_lru
// TLB with FIFO / LRU replacement, entries in one synchronous RAM.
// ----------------------------------------------------------------------------
module tlb_translate_fifo_lru #(
    parameter int TLB_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  tlbt_pkg::t_in_item   i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output tlbt_pkg::t_out_item  o_data,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [16:0]          i_cfg_data
);
    localparam int AW = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
    localparam int RD = 1 << AW;
    localparam int CW = $clog2(TLB_DEPTH + 1);
    // entry word: pid, page, frame, last use, insert time
    localparam int EW = 16 + 32 + 16 + 64 + 64;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [16:0] r_page_size;
    logic [4:0]  r_entries;
    logic [1:0]  r_mode;
    logic [63:0] r_clock;
    logic [TLB_DEPTH-1:0] r_valid_bits;
    tlbt_pkg::t_in_item r_item;
    logic [16:0] r_ps;
    logic [31:0] r_page;
    logic [16:0] r_off;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_idx;      // address issued
    logic          r_rd_v;     // read data valid for r_ridx
    logic [AW-1:0] r_ridx;
    logic          r_hit;
    logic [AW-1:0] r_hit_idx;
    logic [15:0]   r_hit_frame;
    logic [63:0]   r_hit_ins;
    logic          r_inv;
    logic [AW-1:0] r_inv_idx;
    logic [63:0]   r_best_key;
    logic [AW-1:0] r_best_idx;
    logic [47:0]   r_prod;
    logic          r_out_v;
    tlbt_pkg::t_out_item r_out;

    tlbt_pkg::t_div_req w_dreq;
    tlbt_pkg::t_div_rsp w_drsp;
    logic           w_we;
    logic [AW-1:0]  w_waddr;
    logic [EW-1:0]  w_wdata;
    logic [AW-1:0]  w_raddr;
    logic [EW-1:0]  w_rdata;
    logic [15:0]    w_e_pid;
    logic [31:0]    w_e_page;
    logic [15:0]    w_e_frame;
    logic [63:0]    w_e_last;
    logic [63:0]    w_e_ins;
    logic [63:0]    w_key;
    logic           w_match;
    logic [15:0]    w_frame;
    logic [AW-1:0]  w_slot;
    logic           w_fill;

    assign o_ready = (r_state == S_IDLE) && !r_out_v;
    assign w_dreq.start    = i_valid && o_ready;
    assign w_dreq.dividend = i_data.logical_address;
    assign w_dreq.divisor  = (r_page_size == '0) ? 17'd1 : r_page_size;

    tlbt_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_rsp  (w_drsp)
    );

    tlbt_ram #(.WIDTH(EW), .DEPTH(RD)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_raddr = r_idx[AW-1:0];
    assign {w_e_pid, w_e_page, w_e_frame, w_e_last, w_e_ins} = w_rdata;
    assign w_key   = (r_mode == tlbt_pkg::MODE_FIFO) ? w_e_ins : w_e_last;
    assign w_match = r_valid_bits[r_ridx] && (w_e_pid == r_item.pid)
                     && (w_e_page == r_page);
    assign w_slot  = r_inv ? r_inv_idx :
                     ((r_mode == tlbt_pkg::MODE_FIFO || r_mode == tlbt_pkg::MODE_LRU)
                      ? r_best_idx : '0);
    assign w_fill  = (r_item.func == tlbt_pkg::FUNC_FILL) && !r_item.table_error
                     && (r_n != '0);
    assign w_frame = (r_item.func == tlbt_pkg::FUNC_FILL) ? r_item.frame_from_table
                                                          : r_hit_frame;

    // write back once the scan is done (state S_MUL entry cycle)
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_slot;
        w_wdata = {r_item.pid, r_page, r_item.frame_from_table, r_clock, r_clock};
        if (r_state == S_MUL) begin
            if (r_item.func == tlbt_pkg::FUNC_LOOKUP && r_hit) begin
                w_we    = 1'b1;
                w_waddr = r_hit_idx;
                // hit: only last use changes; frame/tags kept from scan copy
                w_wdata = {r_item.pid, r_page, r_hit_frame, r_clock, r_hit_ins};
            end else if (w_fill) begin
                w_we = 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_dreq.start) n_state = S_DIV;
            S_DIV:  if (w_drsp.done) n_state = S_SCAN;
            S_SCAN: if (!r_rd_v && (r_idx >= r_n)) n_state = S_MUL;
            S_MUL:  n_state = S_OUT;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_page_size  <= 17'd4096;
            r_entries    <= 5'd16;
            r_mode       <= tlbt_pkg::MODE_FIFO;
            r_clock      <= '0;
            r_valid_bits <= '0;
            r_out_v      <= 1'b0;
            r_rd_v       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    tlbt_pkg::REG_PAGE_SIZE: r_page_size <= i_cfg_data;
                    tlbt_pkg::REG_ENTRIES:   r_entries   <= i_cfg_data[4:0];
                    tlbt_pkg::REG_MODE:      r_mode      <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (o_valid && i_ready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_dreq.start) begin
                        r_item <= i_data;
                        r_ps   <= w_dreq.divisor;
                        r_n    <= (int'(r_entries) > TLB_DEPTH) ? CW'(TLB_DEPTH)
                                                                : CW'(r_entries);
                    end
                end
                S_DIV: begin
                    r_idx  <= '0;
                    r_rd_v <= 1'b0;
                    r_hit  <= 1'b0;
                    r_inv  <= 1'b0;
                    r_best_idx <= '0;
                    if (w_drsp.done) begin
                        r_page <= w_drsp.quotient;
                        r_off  <= w_drsp.remainder;
                    end
                end
                S_SCAN: begin
                    r_rd_v <= (r_idx < r_n);
                    r_ridx <= r_idx[AW-1:0];
                    if (r_idx < r_n) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    if (r_rd_v) begin
                        // keep insert time of the hit entry for write back
                        if (w_match && !r_hit) begin
                            r_hit       <= 1'b1;
                            r_hit_idx   <= r_ridx;
                            r_hit_frame <= w_e_frame;
                            r_hit_ins   <= w_e_ins;
                        end
                        if (!r_valid_bits[r_ridx] && !r_inv) begin
                            r_inv     <= 1'b1;
                            r_inv_idx <= r_ridx;
                        end
                        if (r_ridx == '0 || w_key < r_best_key) begin
                            r_best_key <= w_key;
                            r_best_idx <= r_ridx;
                        end
                    end
                end
                S_MUL: begin
                    r_prod <= 48'(w_frame) * 48'(r_ps);
                    if ((r_item.func == tlbt_pkg::FUNC_LOOKUP && r_hit) || w_fill) begin
                        r_clock <= r_clock + 64'd1;
                    end
                    if (w_fill) begin
                        r_valid_bits[w_slot] <= 1'b1;
                    end
                end
                S_OUT: begin
                    r_out_v <= 1'b1;
                    r_out.vpn <= r_page;
                    if (r_item.func == tlbt_pkg::FUNC_LOOKUP) begin
                        r_out.status <= r_hit ? tlbt_pkg::ST_HIT : tlbt_pkg::ST_MISS;
                        r_out.physical_address <= r_hit
                            ? (r_prod[31:0] + 32'(r_off)) : 32'd0;
                    end else if (r_item.table_error) begin
                        r_out.status <= tlbt_pkg::ST_ERROR;
                        r_out.physical_address <= 32'd0;
                    end else begin
                        r_out.status <= tlbt_pkg::ST_FILL;
                        r_out.physical_address <= r_prod[31:0] + 32'(r_off);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;
endmodule

[hw/rtl/tlbt_checker.sv]
// ----------------------------------------------------------------------------
// tlbt_checker
// Port-level checks for the TLB block.
// ----------------------------------------------------------------------------
`include "tlb_translate_fifo_lru_assert.svh"

module tlbt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input tlbt_pkg::t_out_item o_data
);
    `TLB_ASSERT_IMPL(a_no_take_while_full, i_clk, i_rst_n, o_valid, !o_ready, "input taken while result pending")
    `TLB_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "second transfer back to back")
    `TLB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data), "result dropped")
    `TLB_ASSERT_IMPL(a_miss_zero, i_clk, i_rst_n, o_valid && (o_data.status == tlbt_pkg::ST_MISS || o_data.status == tlbt_pkg::ST_ERROR), o_data.physical_address == 32'd0, "nonzero address on miss")
endmodule

bind tlb_translate_fifo_lru tlbt_checker u_chk (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_valid(i_valid),
    .o_ready(o_ready),
    .o_valid(o_valid),
    .i_ready(i_ready),
    .o_data (o_data)
);
